// ----- design/aes_ktpc_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-256 key trial package
// Payload types, register map, S-box tables and round functions.
// ----------------------------------------------------------------------------
package aes_ktpc_pkg;

	typedef struct packed {
		logic [63:0] key_bytes_0_7;
		logic [63:0] key_bytes_8_15;
		logic [63:0] key_bytes_16_23;
		logic [63:0] key_bytes_24_31;
		logic [5:0]  key_length;
		logic [15:0] candidate_tag;
	} cand_t;

	typedef struct packed {
		logic [15:0] result_tag;
		logic        prefix_match;
	} result_t;

	typedef logic [0:63][31:0] sched_t;
	typedef logic [0:7][31:0]  block8_t;
	typedef logic [0:255][7:0] sbox_t;

	localparam logic REG_CIPHER_HIGH = 1'b0;
	localparam logic REG_CIPHER_LOW  = 1'b1;

	localparam int unsigned KEY_BYTES  = 32;
	localparam logic [5:0]  KEY_MAX    = 6'd32;
	localparam logic [7:0]  FILL_BYTE  = 8'h30;
	localparam int unsigned ROUNDS     = 14;
	localparam logic [111:0] PREFIX    = 112'h5B7B22636F696E4E616D65223A22;

	localparam logic [0:7][7:0] RCON = {8'h00, 8'h01, 8'h02, 8'h04,
		8'h08, 8'h10, 8'h20, 8'h40};

	localparam sbox_t SBOX = {
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic sbox_t build_inv();
		sbox_t t;
		t = '0;
		for (int i = 0; i < 256; i++) begin
			t[SBOX[i]] = 8'(i);
		end
		return t;
	endfunction

	localparam sbox_t INV_SBOX = build_inv();

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic block8_t expand8(input block8_t prev, input logic [7:0] rc);
		block8_t    nw;
		logic [31:0] t;
		nw = '0;
		for (int i = 0; i < 8; i++) begin
			t = (i == 0) ? prev[7] : nw[i-1];
			if (i == 0) begin
				t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
			end else if (i == 4) begin
				t = sub_word(t);
			end
			nw[i] = prev[i] ^ t;
		end
		return nw;
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		int src;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = r + 4 * ((c + 4 - r) % 4);
				t[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [0:3][7:0] a, x2, x4, x8, m9, m11, m13, m14;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a = s[127 - 32 * c -: 32];
			for (int r = 0; r < 4; r++) begin
				x2[r]  = xtime(a[r]);
				x4[r]  = xtime(x2[r]);
				x8[r]  = xtime(x4[r]);
				m9[r]  = x8[r] ^ a[r];
				m11[r] = x8[r] ^ x2[r] ^ a[r];
				m13[r] = x8[r] ^ x4[r] ^ a[r];
				m14[r] = x8[r] ^ x4[r] ^ x2[r];
			end
			t[127 - 32 * c -: 32] = {
				m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
				m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
				m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
				m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
		end
		return t;
	endfunction

endpackage

// ----- design/aes256_key_trial_prefix_check_top.sv -----
// ----------------------------------------------------------------------------
// AES-256 key trial with known plaintext prefix
// Pads a candidate password to a 256-bit key, decrypts the configured block
// and flags a match of the first 14 plaintext bytes against the fixed prefix.
// ----------------------------------------------------------------------------
// One candidate enters per cycle while the result port does not stall. One
// stage pads the key, seven stages expand the key schedule eight words at a
// time, and fifteen stages run the initial key addition and the fourteen
// inverse rounds, one step per stage. A stall at the result port holds the
// whole pipeline. The ciphertext block is captured when a candidate enters.
module aes256_key_trial_prefix_check_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cand_valid,
	output logic                  cand_ready,
	input  aes_ktpc_pkg::cand_t   cand,
	output logic                  result_valid,
	input  logic                  result_ready,
	output aes_ktpc_pkg::result_t result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);

	localparam int unsigned NS = 23;

	logic [63:0] cipher_high_q, cipher_low_q;
	logic        adv;

	logic                  valid_s [NS];
	logic [15:0]           tag_s   [NS];
	logic [127:0]          state_s [NS];
	aes_ktpc_pkg::sched_t  sched_s [NS];
	logic                  match_s;

	logic [127:0]          state_n [NS];
	aes_ktpc_pkg::sched_t  sched_n [NS];
	logic                  match_n;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == aes_ktpc_pkg::REG_CIPHER_LOW) ? cipher_low_q : cipher_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_high_q <= '0;
			cipher_low_q  <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[3] == aes_ktpc_pkg::REG_CIPHER_LOW) begin
				cipher_low_q <= pwdata;
			end else begin
				cipher_high_q <= pwdata;
			end
		end
	end

	assign adv          = !valid_s[NS-1] || result_ready;
	assign cand_ready   = adv;
	assign result_valid = valid_s[NS-1];
	assign result       = '{result_tag: tag_s[NS-1], prefix_match: match_s};

	// pad key
	always_comb begin
		logic [255:0] raw;
		logic [5:0]   len;
		logic [255:0] key;
		raw = {cand.key_bytes_0_7, cand.key_bytes_8_15, cand.key_bytes_16_23,
			cand.key_bytes_24_31};
		len = (cand.key_length > aes_ktpc_pkg::KEY_MAX) ? aes_ktpc_pkg::KEY_MAX
			: cand.key_length;
		for (int i = 0; i < aes_ktpc_pkg::KEY_BYTES; i++) begin
			key[255 - 8 * i -: 8] = (6'(i) < len) ? raw[255 - 8 * i -: 8]
				: aes_ktpc_pkg::FILL_BYTE;
		end
		sched_n[0]         = '0;
		sched_n[0][0:7]    = key;
		state_n[0]         = {cipher_high_q, cipher_low_q};
	end

	for (genvar k = 1; k < NS; k++) begin : g_stage
		if (k <= 7) begin : g_expand
			always_comb begin
				sched_n[k] = sched_s[k-1];
				sched_n[k][8*k +: 8] = aes_ktpc_pkg::expand8(sched_s[k-1][8*k-8 +: 8],
					aes_ktpc_pkg::RCON[k]);
				state_n[k] = state_s[k-1];
			end
		end else if (k == 8) begin : g_first
			always_comb begin
				sched_n[k] = sched_s[k-1];
				state_n[k] = state_s[k-1] ^ sched_s[k-1][4*aes_ktpc_pkg::ROUNDS +: 4];
			end
		end else if (k < NS - 1) begin : g_round
			always_comb begin
				sched_n[k] = sched_s[k-1];
				state_n[k] = aes_ktpc_pkg::inv_mix(
					aes_ktpc_pkg::inv_shift_sub(state_s[k-1]) ^ sched_s[k-1][4*(22-k) +: 4]);
			end
		end else begin : g_last
			always_comb begin
				sched_n[k] = sched_s[k-1];
				state_n[k] = aes_ktpc_pkg::inv_shift_sub(state_s[k-1]) ^ sched_s[k-1][0 +: 4];
			end
		end
	end

	assign match_n = (state_n[NS-1][127:16] == aes_ktpc_pkg::PREFIX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s[0] <= cand_valid;
			for (int k = 1; k < NS; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0]   <= cand.candidate_tag;
			state_s[0] <= state_n[0];
			sched_s[0] <= sched_n[0];
			for (int k = 1; k < NS; k++) begin
				tag_s[k]   <= tag_s[k-1];
				state_s[k] <= state_n[k];
				sched_s[k] <= sched_n[k];
			end
			match_s <= match_n;
		end
	end

endmodule

// ----- design/aes_ktpc_checker.sv -----
// ----------------------------------------------------------------------------
// AES-256 key trial port checker
// Watches the top level ports and binds to every instance of the top level.
// ----------------------------------------------------------------------------
module aes_ktpc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  result_valid,
	input logic                  result_ready,
	input aes_ktpc_pkg::result_t result,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [3:0]            paddr,
	input logic [63:0]           pwdata,
	input logic [63:0]           prdata,
	input logic                  pready
);

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

	a_reg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=>
		(paddr[3] != $past(paddr[3])) || (psel && penable && pwrite) ||
		(prdata == $past(pwdata)))
		else $error("register readback differs from written value");

	a_idle_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !result_valid)
		else $error("result transaction straight after reset");

endmodule

bind aes256_key_trial_prefix_check_top aes_ktpc_checker u_aes_ktpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.pready       (pready)
);
